[hw/rtl/spq_pkg.sv]
// Package: shared types, codes and defaults for the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 64;
    localparam int PRIO_W         = 32;
    localparam int FIELD_VAL_W    = 64;
    localparam int STATUS_W       = 3;
    localparam int COUNT_W        = 5;
    localparam int S_DATA_W       = 104;
    localparam int M_DATA_W       = 176;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_CHANGE  = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_RAISED    = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     seed;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_EXEC   = 2'd1,
        FSM_INSERT = 2'd2,
        FSM_REPORT = 2'd3
    } fsm_t;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// One queue slot: holds an entry, compares it against the key, shifts with its neighbors.
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire cell_ctl_t             ctl,
    input  wire logic                  valid,
    input  wire logic [VALUE_BITS-1:0] key_value,
    input  wire logic [PRIO_W-1:0]     key_prio,
    input  wire logic [VALUE_BITS-1:0] left_value,
    input  wire logic [PRIO_W-1:0]     left_prio,
    input  wire logic                  left_ahead,
    input  wire logic [VALUE_BITS-1:0] right_value,
    input  wire logic [PRIO_W-1:0]     right_prio,
    input  wire logic                  seen_in,
    output logic [VALUE_BITS-1:0]      value,
    output logic [PRIO_W-1:0]          prio,
    output logic                       ahead,
    output logic                       seen_out,
    output logic                       raised
);

    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [PRIO_W-1:0]     prio_reg, prio_next;
    logic                  match;

    assign value = value_reg;
    assign prio  = prio_reg;

    assign ahead = valid && (($signed(prio_reg) < $signed(key_prio)) ||
                             ((prio_reg == key_prio) && (value_reg < key_value)));
    assign match    = valid && (value_reg == key_value);
    assign seen_out = seen_in || match;
    assign raised   = match && !seen_in && ($signed(key_prio) > $signed(prio_reg));

    always_comb begin
        value_next = value_reg;
        prio_next  = prio_reg;
        case (ctl.op)
            CELL_INSERT: begin
                if (!ahead) begin
                    if (left_ahead) begin
                        value_next = key_value;
                        prio_next  = key_prio;
                    end else begin
                        value_next = left_value;
                        prio_next  = left_prio;
                    end
                end
            end
            CELL_REMOVE: begin
                if (seen_out) begin
                    value_next = right_value;
                    prio_next  = right_prio;
                end
            end
            default: begin
                value_next = value_reg;
                prio_next  = prio_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

`default_nettype wire

[hw/rtl/spq_chain.sv]
// Row of queue cells, most urgent slot first, with neighbor links.
`default_nettype none

module spq_chain
    import spq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                  aclk,
    input  wire cell_ctl_t             ctl,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [VALUE_BITS-1:0] key_value,
    input  wire logic [PRIO_W-1:0]     key_prio,
    output logic [VALUE_BITS-1:0]      head_value,
    output logic [PRIO_W-1:0]          head_prio,
    output logic                       found,
    output logic                       raised
);

    logic [VALUE_BITS-1:0] cell_value [DEPTH];
    logic [PRIO_W-1:0]     cell_prio  [DEPTH];
    logic [DEPTH-1:0]      cell_ahead;
    logic [DEPTH-1:0]      cell_raised;
    logic [DEPTH:0]        seen;

    assign seen[0] = ctl.seed;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [VALUE_BITS-1:0] lv, rv;
        logic [PRIO_W-1:0]     lp, rp;
        logic                  la;

        if (i == 0) begin : g_first
            assign lv = '0;
            assign lp = '0;
            assign la = 1'b1;
        end else begin : g_mid
            assign lv = cell_value[i-1];
            assign lp = cell_prio[i-1];
            assign la = cell_ahead[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign rv = '0;
            assign rp = '0;
        end else begin : g_inner
            assign rv = cell_value[i+1];
            assign rp = cell_prio[i+1];
        end

        spq_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (ctl),
            .valid      (count > CNT_W'(i)),
            .key_value  (key_value),
            .key_prio   (key_prio),
            .left_value (lv),
            .left_prio  (lp),
            .left_ahead (la),
            .right_value(rv),
            .right_prio (rp),
            .seen_in    (seen[i]),
            .value      (cell_value[i]),
            .prio       (cell_prio[i]),
            .ahead      (cell_ahead[i]),
            .seen_out   (seen[i+1]),
            .raised     (cell_raised[i])
        );
    end

    assign head_value = cell_value[0];
    assign head_prio  = cell_prio[0];
    assign found      = seen[DEPTH];
    assign raised     = |cell_raised;

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// Top level: command sequencer, entry count and result register around the cell row.
//
//  port group | dir | fields (lsb first)
//  s_*        | in  | command, item_value, item_priority
//  m_*        | out | status, taken_value, head_value, head_priority, is_empty, entry_count
//
// One beat is taken at a time: enqueue, dequeue and clear step through idle, execute
// and report before the next beat is taken; change priority adds an insert state
// when the entry is found and not raised (remove, then reinsert).
// All slots update in parallel each cycle; the cell row is the only storage for entries.
// Synchronous active-low reset empties the queue and drops any pending result.
// A stalled result holds in the output register; the next beat is taken and waits
// in report until the output register drains.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // command[1:0], item_value[65:2], item_priority[97:66], zero pad
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status[2:0], taken_value[66:3], head_value[130:67], head_priority[162:131],
    // is_empty[163], entry_count[168:164], zero pad
    output logic [M_DATA_W-1:0]      m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    fsm_t                  state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [PRIO_W-1:0]     prio_reg, prio_next;
    status_t               status_reg, status_next;
    logic [VALUE_BITS-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    cell_ctl_t             ctl;
    logic [VALUE_BITS-1:0] head_value;
    logic [PRIO_W-1:0]     head_prio;
    logic                  found, raised;
    logic                  is_full, is_empty, load_out;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    spq_chain #(
        .DEPTH     (DEPTH),
        .VALUE_BITS(VALUE_BITS),
        .CNT_W     (CNT_W)
    ) u_chain (
        .aclk      (aclk),
        .ctl       (ctl),
        .count     (count_reg),
        .key_value (value_reg),
        .key_prio  (prio_reg),
        .head_value(head_value),
        .head_prio (head_prio),
        .found     (found),
        .raised    (raised)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_tvalid) state_next = FSM_EXEC;
            end
            FSM_EXEC: begin
                if (cmd_reg == CMD_CHANGE && found && !raised) state_next = FSM_INSERT;
                else state_next = FSM_REPORT;
            end
            FSM_INSERT: state_next = FSM_REPORT;
            FSM_REPORT: begin
                if (!m_valid_reg || m_tready) state_next = FSM_IDLE;
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        ctl.op      = CELL_HOLD;
        ctl.seed    = 1'b0;
        cmd_next    = cmd_reg;
        value_next  = value_reg;
        prio_next   = prio_reg;
        status_next = status_reg;
        taken_next  = taken_reg;
        count_next  = count_reg;
        load_out    = 1'b0;
        case (state_reg)
            FSM_IDLE: begin
                s_tready    = 1'b1;
                cmd_next    = cmd_t'(s_tdata[1:0]);
                value_next  = s_tdata[2 +: VALUE_BITS];
                prio_next   = s_tdata[66 +: PRIO_W];
                status_next = ST_OK;
                taken_next  = '0;
            end
            FSM_EXEC: begin
                case (cmd_reg)
                    CMD_ENQUEUE: begin
                        if (is_full) begin
                            status_next = ST_FULL;
                        end else begin
                            ctl.op     = CELL_INSERT;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_DEQUEUE: begin
                        if (is_empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            taken_next = head_value;
                            ctl.op     = CELL_REMOVE;
                            ctl.seed   = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    CMD_CHANGE: begin
                        if (!found) begin
                            status_next = ST_NOT_FOUND;
                        end else if (raised) begin
                            status_next = ST_RAISED;
                        end else begin
                            ctl.op     = CELL_REMOVE;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    CMD_CLEAR: count_next = '0;
                    default: count_next = count_reg;
                endcase
            end
            FSM_INSERT: begin
                ctl.op     = CELL_INSERT;
                count_next = count_reg + 1'b1;
            end
            FSM_REPORT: load_out = !m_valid_reg || m_tready;
            default: load_out = 1'b0;
        endcase
    end

    always_comb begin
        m_data_next = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (load_out) begin
            m_valid_next          = 1'b1;
            m_data_next           = '0;
            m_data_next[2:0]      = status_reg;
            m_data_next[66:3]     = FIELD_VAL_W'(taken_reg);
            m_data_next[130:67]   = is_empty ? '0 : FIELD_VAL_W'(head_value);
            m_data_next[162:131]  = is_empty ? '0 : head_prio;
            m_data_next[163]      = is_empty;
            m_data_next[168:164]  = COUNT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        value_reg  <= value_next;
        prio_reg   <= prio_next;
        status_reg <= status_next;
        taken_reg  <= taken_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

[tb/tb_sorted_priority_queue.sv]
// Testbench for sorted_priority_queue: directed table plus random commands, scoreboarded.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int N_ROWS      = 23;
    localparam int N_RANDOM    = 1415;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 200000;

    typedef struct packed {
        status_t     status;
        logic [63:0] taken;
        logic [63:0] head_v;
        logic [31:0] head_p;
        logic        empty;
        logic [4:0]  count;
    } pq_result_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] value;
        logic [31:0] prio;
        logic [4:0]  reps;
        logic        typed;
        pq_result_t  want;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // queue image kept by the predictor, most urgent first
    logic [63:0]        pq_val [DEPTH];
    logic signed [31:0] pq_pri [DEPTH];
    int                 pq_count;

    pq_result_t expected_q [$];
    stim_row_t  stim_table [N_ROWS];
    int         n_errors;
    int         n_results;
    int         cycle_count;
    bit         idle_on;
    bit         hold_off_req;

    sorted_priority_queue u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic void pq_insert(logic [63:0] v, logic signed [31:0] p);
        int pos;
        int i;
        pos = 0;
        while (pos < pq_count &&
               (pq_pri[pos] < p || (pq_pri[pos] == p && pq_val[pos] < v)))
            pos++;
        for (i = pq_count; i > pos; i--) begin
            pq_val[i] = pq_val[i-1];
            pq_pri[i] = pq_pri[i-1];
        end
        pq_val[pos] = v;
        pq_pri[pos] = p;
        pq_count++;
    endfunction

    function automatic void pq_remove(int pos);
        int i;
        for (i = pos; i + 1 < pq_count; i++) begin
            pq_val[i] = pq_val[i+1];
            pq_pri[i] = pq_pri[i+1];
        end
        pq_count--;
    endfunction

    function automatic pq_result_t apply_command(cmd_t c, logic [63:0] v, logic signed [31:0] p);
        pq_result_t r;
        int         i;
        bit         hit;
        r        = '0;
        r.status = ST_OK;
        hit      = 1'b0;
        case (c)
            CMD_ENQUEUE: begin
                if (pq_count >= DEPTH)
                    r.status = ST_FULL;
                else
                    pq_insert(v, p);
            end
            CMD_DEQUEUE: begin
                if (pq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.taken = pq_val[0];
                    pq_remove(0);
                end
            end
            CMD_CHANGE: begin
                r.status = ST_NOT_FOUND;
                for (i = 0; i < pq_count && !hit; i++) begin
                    if (pq_val[i] == v) begin
                        hit = 1'b1;
                        if (p > pq_pri[i]) begin
                            r.status = ST_RAISED;
                        end else begin
                            pq_remove(i);
                            pq_insert(v, p);
                            r.status = ST_OK;
                        end
                    end
                end
            end
            default: pq_count = 0;
        endcase
        if (pq_count != 0) begin
            r.head_v = pq_val[0];
            r.head_p = pq_pri[0];
        end
        r.empty = (pq_count == 0);
        r.count = pq_count[4:0];
        return r;
    endfunction

    function automatic logic [63:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 64'($urandom_range(0, 15));
        if (r < 85)
            return {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return 64'h0;
            1:       return 64'hFFFF_FFFF_FFFF_FFFF;
            2:       return 64'h8000_0000_0000_0000;
            default: return 64'h7FFF_FFFF_FFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 8) - 4;
        if (r < 85)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0;
        endcase
    endfunction

    // offer one beat, wait for the handshake, then record what must come back
    task automatic put_beat(cmd_t c, logic [63:0] v, logic [31:0] p,
                            logic typed, pq_result_t want);
        pq_result_t r;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, p, v, c};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = apply_command(c, v, p);
        expected_q.push_back(typed ? want : r);
    endtask

    initial begin : rx_side
        m_tready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        pq_result_t got;
        pq_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = status_t'(m_tdata[2:0]);
            got.taken  = m_tdata[66:3];
            got.head_v = m_tdata[130:67];
            got.head_p = m_tdata[162:131];
            got.empty  = m_tdata[163];
            got.count  = m_tdata[168:164];
            if (expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("result %0d: no beat outstanding, got %h", n_results, m_tdata);
            end else begin
                want = expected_q.pop_front();
                if (got.status !== want.status || got.taken !== want.taken ||
                    got.head_v !== want.head_v || got.head_p !== want.head_p ||
                    got.empty !== want.empty || got.count !== want.count) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("result %0d mismatch: exp st=%0d taken=%h head=%h/%0d e=%0b n=%0d",
                                 n_results, want.status, want.taken, want.head_v,
                                 $signed(want.head_p), want.empty, want.count);
                        $display("    got st=%0d taken=%h head=%h/%0d e=%0b n=%0d",
                                 got.status, got.taken, got.head_v,
                                 $signed(got.head_p), got.empty, got.count);
                    end
                end
            end
            n_results++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL sorted_priority_queue");
            $finish;
        end
    end

    initial begin : stimulus
        int          n;
        int          k;
        int          r;
        int          enq_pct;
        cmd_t        c;
        logic [63:0] v;
        logic [31:0] p;

        n_errors     = 0;
        n_results    = 0;
        cycle_count  = 0;
        pq_count     = 0;
        idle_on      = 1'b1;
        hold_off_req = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;

        stim_table[0]  = '{CMD_DEQUEUE, 64'd0, 32'd0, 5'd1, 1'b1,
                           '{ST_EMPTY, 64'd0, 64'd0, 32'd0, 1'b1, 5'd0}};
        stim_table[1]  = '{CMD_CHANGE, 64'd5, 32'd0, 5'd1, 1'b1,
                           '{ST_NOT_FOUND, 64'd0, 64'd0, 32'd0, 1'b1, 5'd0}};
        stim_table[2]  = '{CMD_ENQUEUE, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b1,
                           '{ST_OK, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 5'd1}};
        stim_table[3]  = '{CMD_ENQUEUE, 64'd0, 32'h8000_0000, 5'd1, 1'b1,
                           '{ST_OK, 64'd0, 64'd0, 32'h8000_0000, 1'b0, 5'd2}};
        stim_table[4]  = '{CMD_ENQUEUE, 64'd5, 32'd0, 5'd1, 1'b0, '0};
        stim_table[5]  = '{CMD_ENQUEUE, 64'd5, 32'd0, 5'd1, 1'b0, '0};
        stim_table[6]  = '{CMD_ENQUEUE, 64'd3, 32'd0, 5'd1, 1'b0, '0};
        stim_table[7]  = '{CMD_ENQUEUE, 64'd9, 32'd2, 5'd1, 1'b0, '0};
        stim_table[8]  = '{CMD_ENQUEUE, 64'd9, 32'hFFFF_FFFF, 5'd1, 1'b0, '0};
        stim_table[9]  = '{CMD_CHANGE, 64'd5, 32'd10, 5'd1, 1'b1,
                           '{ST_RAISED, 64'd0, 64'd0, 32'h8000_0000, 1'b0, 5'd7}};
        // first match of 9 is the more urgent one, so this is a raise
        stim_table[10] = '{CMD_CHANGE, 64'd9, 32'd1, 5'd1, 1'b0, '0};
        stim_table[11] = '{CMD_CHANGE, 64'd5, 32'd0, 5'd1, 1'b0, '0};
        stim_table[12] = '{CMD_CHANGE, 64'd5, 32'hFFFF_FFFB, 5'd1, 1'b0, '0};
        stim_table[13] = '{CMD_CHANGE, 64'd77, 32'd0, 5'd1, 1'b0, '0};
        stim_table[14] = '{CMD_DEQUEUE, 64'd0, 32'd0, 5'd1, 1'b0, '0};
        stim_table[15] = '{CMD_CLEAR, 64'd0, 32'd0, 5'd1, 1'b1,
                           '{ST_OK, 64'd0, 64'd0, 32'd0, 1'b1, 5'd0}};
        // fill: values 0x100.., priorities 100 down to 85
        stim_table[16] = '{CMD_ENQUEUE, 64'h100, 32'd100, 5'd16, 1'b0, '0};
        stim_table[17] = '{CMD_ENQUEUE, 64'd1, 32'hFFFF_FFFF, 5'd1, 1'b1,
                           '{ST_FULL, 64'd0, 64'h10F, 32'd85, 1'b0, 5'd16}};
        stim_table[18] = '{CMD_CHANGE, 64'h100, 32'hFFFF_FFF9, 5'd1, 1'b0, '0};
        stim_table[19] = '{CMD_DEQUEUE, 64'd0, 32'd0, 5'd1, 1'b0, '0};
        stim_table[20] = '{CMD_CHANGE, 64'h105, 32'd200, 5'd1, 1'b0, '0};
        stim_table[21] = '{CMD_CLEAR, 64'd0, 32'd0, 5'd1, 1'b1,
                           '{ST_OK, 64'd0, 64'd0, 32'd0, 1'b1, 5'd0}};
        stim_table[22] = '{CMD_DEQUEUE, 64'd0, 32'd0, 5'd1, 1'b1,
                           '{ST_EMPTY, 64'd0, 64'd0, 32'd0, 1'b1, 5'd0}};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (n = 0; n < N_ROWS; n++) begin
            for (k = 0; k < stim_table[n].reps; k++)
                put_beat(stim_table[n].cmd, stim_table[n].value + k, stim_table[n].prio - k,
                         stim_table[n].typed, stim_table[n].want);
        end

        for (n = 0; n < N_RANDOM; n++) begin
            idle_on = (n < N_RANDOM - 200) && !(n >= 600 && n < 700);
            if (n == 200)
                hold_off_req = 1'b1;
            // enqueue share sweeps so the queue runs both full and dry
            enq_pct = 20 + 15 * ((n / 100) % 5);
            r = $urandom_range(0, 99);
            if (r < 2)
                c = CMD_CLEAR;
            else if (r < 2 + enq_pct)
                c = CMD_ENQUEUE;
            else if ($urandom_range(0, 1) == 0)
                c = CMD_CHANGE;
            else
                c = CMD_DEQUEUE;
            v = pick_value();
            p = pick_prio();
            if (c == CMD_CHANGE && pq_count > 0 && $urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, pq_count - 1);
                v = pq_val[k];
                case ($urandom_range(0, 2))
                    0:       p = pq_pri[k];
                    1:       p = pq_pri[k] - $urandom_range(1, 3);
                    default: p = pq_pri[k] + $urandom_range(1, 3);
                endcase
            end
            put_beat(c, v, p, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_errors == 0 && expected_q.size() == 0)
            $display("PASS sorted_priority_queue");
        else
            $display("FAIL sorted_priority_queue");
        $finish;
    end

endmodule
